// ===== hdl/pdf_object_rc4_encrypt_assert.svh =====
// assertion macros for the pdf object rc4 cipher
`ifndef PDF_OBJECT_RC4_ENCRYPT_ASSERT_SVH
`define PDF_OBJECT_RC4_ENCRYPT_ASSERT_SVH
// implication checked every cycle outside reset
`define RC4_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define RC4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/pdfrc4_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfrc4_pkg
// shared constants and md5 helpers for the per-object rc4 cipher
// ----------------------------------------------------------------------------
package pdfrc4_pkg;
  localparam int MaxKeyBytes = 16;
  localparam int MinKeyBytes = 5;
  localparam int DigestBytes = 16;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] Md5InitA = 32'h67452301;
  localparam logic [31:0] Md5InitB = 32'hefcdab89;
  localparam logic [31:0] Md5InitC = 32'h98badcfe;
  localparam logic [31:0] Md5InitD = 32'h10325476;

  function automatic logic [31:0] md5_sine(input logic [5:0] k);
    logic [31:0] t [64];
    t = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[k];
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] k);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{k[5:4], k[1:0]}];
  endfunction

  function automatic logic [3:0] md5_index(input logic [5:0] k);
    logic [3:0] g;
    unique case (k[5:4])
      2'd0: g = k[3:0];
      2'd1: g = 4'(5 * k[3:0] + 1);
      2'd2: g = 4'(3 * k[3:0] + 5);
      default: g = 4'(7 * k[3:0]);
    endcase
    return g;
  endfunction
endpackage

// ===== hdl/pdfrc4_md5.sv =====
// ----------------------------------------------------------------------------
// pdfrc4_md5
// one-block md5 over the object key message, one round per cycle
// ----------------------------------------------------------------------------
module pdfrc4_md5 #(
  parameter int MAX_KEY_BYTES = pdfrc4_pkg::MaxKeyBytes
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [MAX_KEY_BYTES*8-1:0] file_key,
  input  logic [4:0]                 key_len,
  input  logic [23:0]                obj_num,
  output logic                       done,
  output logic [127:0]               digest
);
  import pdfrc4_pkg::*;

  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   k_r;
  logic         busy_r, done_r;
  logic [31:0]  f, w, sum, rot;
  logic [8:0]   bits;

  always_comb begin
    blk_nxt = '0;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (i < key_len) blk_nxt[i*8 +: 8] = file_key[i*8 +: 8];
    end
    blk_nxt[key_len*8 +: 24]        = obj_num;
    blk_nxt[(key_len+5)*8 +: 8]     = 8'h80;
    bits                            = 9'({key_len, 3'b000}) + 9'd40;
    blk_nxt[448 +: 9]               = bits;
  end

  always_comb begin
    unique case (k_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    w   = blk_r[md5_index(k_r)*32 +: 32];
    sum = a_r + f + md5_sine(k_r) + w;
    rot = (sum << md5_rot(k_r)) | (sum >> (6'd32 - {1'b0, md5_rot(k_r)}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
      a_r <= Md5InitA; b_r <= Md5InitB; c_r <= Md5InitC; d_r <= Md5InitD;
    end else begin
      done_r <= !start && busy_r && (k_r == 6'd63);
      if (start) begin
        blk_r  <= blk_nxt;
        busy_r <= 1'b1;
        k_r    <= '0;
        a_r <= Md5InitA; b_r <= Md5InitB; c_r <= Md5InitC; d_r <= Md5InitD;
      end else if (busy_r) begin
        a_r <= d_r;
        d_r <= c_r;
        c_r <= b_r;
        b_r <= b_r + rot;
        k_r <= k_r + 6'd1;
        if (k_r == 6'd63) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign digest = {d_r + Md5InitD, c_r + Md5InitC, b_r + Md5InitB, a_r + Md5InitA};
endmodule

// ===== hdl/pdfrc4_core.sv =====
// ----------------------------------------------------------------------------
// pdfrc4_core
// s-box memory with key schedule and keystream sequencer
// ----------------------------------------------------------------------------
module pdfrc4_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         ksa_start,
  input  logic [127:0] obj_key,
  input  logic [4:0]   obj_key_len,
  input  logic         data_go,
  output logic         ks_valid,
  output logic [7:0]   ks_byte,
  output logic         idle
);
  import pdfrc4_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_KRD_I, S_KRD_J, S_KSWAP,
    S_DRD_I, S_DRD_J, S_DSWAP, S_DRD_T, S_DOUT
  } state_t;

  logic [7:0] sbox [256];
  state_t     state_r;
  logic [7:0] i_r, j_r, si_r, ctr_r;
  logic [3:0] kidx_r;
  logic       ks_valid_r;
  logic [7:0] ks_r;
  logic [7:0] rd_q;
  logic [7:0] rd_addr;
  logic       we_a, we_b;
  logic [7:0] wa_addr, wa_data, wb_addr, wb_data;
  logic [7:0] jk, jd;

  assign jk = j_r + rd_q + obj_key[kidx_r*8 +: 8];
  assign jd = j_r + rd_q;

  always_comb begin
    we_a = 1'b0; wa_addr = ctr_r; wa_data = ctr_r;
    we_b = 1'b0; wb_addr = j_r;   wb_data = si_r;
    rd_addr = i_r;
    unique case (state_r)
      // prefetch s[i+1] for the next data byte
      S_IDLE:  rd_addr = i_r + 8'd1;
      S_FILL: begin
        we_a = 1'b1; rd_addr = 8'd0;
      end
      S_KRD_I: rd_addr = jk;
      S_KRD_J: rd_addr = j_r;
      S_KSWAP: begin
        we_a = 1'b1; wa_addr = i_r; wa_data = rd_q;
        we_b = 1'b1; wb_addr = j_r; wb_data = si_r;
        rd_addr = i_r + 8'd1;
      end
      S_DRD_I: rd_addr = jd;
      S_DRD_J: rd_addr = j_r;
      S_DSWAP: begin
        we_a = 1'b1; wa_addr = i_r; wa_data = rd_q;
        we_b = 1'b1; wb_addr = j_r; wb_data = si_r;
        rd_addr = rd_q + si_r;
      end
      default: rd_addr = i_r;
    endcase
  end

  // two write ports as one dual-port array; second write wins on same address,
  // a read of an entry written at the same edge returns the new value
  always_ff @(posedge clk) begin
    if (we_a && !(we_b && wa_addr == wb_addr)) sbox[wa_addr] <= wa_data;
    if (we_b) sbox[wb_addr] <= wb_data;
    if (we_b && wb_addr == rd_addr) rd_q <= wb_data;
    else if (we_a && wa_addr == rd_addr) rd_q <= wa_data;
    else rd_q <= sbox[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      ctr_r      <= '0;
      kidx_r     <= '0;
      ks_valid_r <= 1'b0;
    end else begin
      ks_valid_r <= (state_r == S_DOUT);
      unique case (state_r)
        S_IDLE: begin
          if (ksa_start) begin
            ctr_r <= '0; state_r <= S_FILL;
          end else if (data_go) begin
            i_r <= i_r + 8'd1; state_r <= S_DRD_I;
          end
        end
        S_FILL: begin
          ctr_r <= ctr_r + 8'd1;
          if (ctr_r == 8'hff) begin
            i_r <= '0; j_r <= '0; kidx_r <= '0; state_r <= S_KRD_I;
          end
        end
        S_KRD_I: begin
          si_r <= rd_q; j_r <= jk;
          kidx_r <= (5'(kidx_r) + 5'd1 == obj_key_len) ? '0 : kidx_r + 4'd1;
          state_r <= S_KRD_J;
        end
        S_KRD_J: state_r <= S_KSWAP;
        S_KSWAP: begin
          if (i_r == 8'hff) begin
            i_r <= '0; j_r <= '0; state_r <= S_IDLE;
          end else begin
            i_r <= i_r + 8'd1; state_r <= S_KRD_I;
          end
        end
        S_DRD_I: begin
          si_r <= rd_q; j_r <= jd; state_r <= S_DRD_J;
        end
        S_DRD_J: state_r <= S_DSWAP;
        S_DSWAP: state_r <= S_DRD_T;
        S_DRD_T: begin
          ks_r <= rd_q; state_r <= S_DOUT;
        end
        S_DOUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ks_valid = ks_valid_r;
  assign ks_byte  = ks_r;
  assign idle     = (state_r == S_IDLE);

  `include "pdf_object_rc4_encrypt_assert.svh"
  `RC4_ASSERT_NEXT(a_fill_exit, state_r == S_FILL && ctr_r == 8'hff, state_r == S_KRD_I)
  `RC4_ASSERT_NEXT(a_ks_after_out, state_r == S_DOUT, ks_valid_r)
  `RC4_ASSERT_IMP(a_ks_only_idle, ks_valid_r, state_r == S_IDLE)
endmodule

// ===== hdl/pdf_object_rc4_encrypt.sv =====
// ----------------------------------------------------------------------------
// pdf_object_rc4_encrypt
// per-object rc4 cipher of the pdf standard security handler
// ----------------------------------------------------------------------------
// channel | dir | transfer
// in_     | in  | start (tuser=0, object number) or data byte (tuser=1)
// out_    | out | enciphered byte with tlast, one per data transfer
// cfg_    | in  | register write, index 0 key low, 1 key high, 2 key length
// a start runs the md5 rounds, then the s-box fill and the key schedule
// a data byte is paced by the reads and writes of the s-box memory
// the s-box has no clearing pass; reset clears only the control state
// a waiting result blocks the next transfer until out_tready takes it
module pdf_object_rc4_encrypt #(
  parameter int MAX_KEY_BYTES = pdfrc4_pkg::MaxKeyBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // object_number[23:0], data_byte[31:24]
  input  logic        in_tuser,   // mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import pdfrc4_pkg::*;

  logic [63:0] key_lo_r, key_hi_r;
  logic [4:0]  key_len_r;
  logic [4:0]  n_eff;
  logic [4:0]  okey_len_r;
  logic        busy_r;     // start in progress
  logic        pend_r;     // data byte in progress
  logic [7:0]  data_r;
  logic        last_r;
  logic        ov_r;
  logic [7:0]  ob_r;
  logic        ol_r;
  logic        md5_done, ks_valid, core_idle, acc;
  logic [7:0]  ks_byte;
  logic [127:0] digest;
  logic [127:0] fkey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_hi_r <= '0; key_len_r <= 5'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_lo_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_hi_r  <= cfg_wdata;
        CFG_KEY_LEN:  key_len_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // out-of-range lengths fall back to the minimum
  assign n_eff = (key_len_r < 5'(MinKeyBytes) || key_len_r > 5'(MAX_KEY_BYTES))
                 ? 5'(MinKeyBytes) : key_len_r;
  assign fkey  = {key_hi_r, key_lo_r};

  assign in_tready = !busy_r && !pend_r && !ov_r && core_idle;
  assign acc       = in_tvalid && in_tready;

  pdfrc4_md5 #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_md5 (
    .clk, .rst_n,
    .start   (acc && !in_tuser),
    .file_key(fkey[MAX_KEY_BYTES*8-1:0]),
    .key_len (n_eff),
    .obj_num (in_tdata[23:0]),
    .done    (md5_done),
    .digest  (digest)
  );

  pdfrc4_core u_core (
    .clk, .rst_n,
    .ksa_start  (md5_done),
    .obj_key    (digest),
    .obj_key_len(okey_len_r),
    .data_go    (acc && in_tuser),
    .ks_valid   (ks_valid),
    .ks_byte    (ks_byte),
    .idle       (core_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; pend_r <= 1'b0; ov_r <= 1'b0; okey_len_r <= 5'd10;
    end else begin
      if (acc && !in_tuser) begin
        busy_r     <= 1'b1;
        okey_len_r <= (n_eff > 5'd11) ? 5'd16 : n_eff + 5'd5;
      end
      if (md5_done) busy_r <= 1'b0;
      if (acc && in_tuser) begin
        pend_r <= 1'b1; data_r <= in_tdata[31:24]; last_r <= in_tlast;
      end
      if (ks_valid) begin
        pend_r <= 1'b0; ov_r <= 1'b1;
      end else if (ov_r && out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ks_valid) begin
      ob_r <= data_r ^ ks_byte;
      ol_r <= last_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = ol_r;
endmodule

// ===== tb/sv/pdf_rc4_checker.sv =====
// ----------------------------------------------------------------------------
// pdf_rc4_checker
// watches the input, output and register-write ports of the per-object rc4
// cipher, predicts every enciphered byte and compares it with the block's
// ----------------------------------------------------------------------------
module pdf_rc4_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count,
  output int          byte_count
);
  import pdfrc4_pkg::*;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_flag;
  } cipher_out_t;

  cipher_out_t cipher_q[$];

  logic [63:0] key_lo, key_hi;
  logic [4:0]  key_len;
  logic [7:0]  perm [256];
  logic [7:0]  ptr_i, ptr_j;

  localparam logic [31:0] SineTab [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int ShiftTab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15,
                                   21};

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // md5 of the short key message, then the rc4 key schedule
  task automatic schedule_object_key(input logic [23:0] obj);
    logic [7:0]  msg [64];
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, s;
    logic [31:0] dig [4];
    logic [7:0]  okey [16];
    logic [7:0]  jj, tmp;
    int n, klen, g;
    n = (key_len < MinKeyBytes || key_len > MaxKeyBytes) ? MinKeyBytes : key_len;
    for (int k = 0; k < 64; k++) msg[k] = 8'h00;
    for (int k = 0; k < n; k++)
      msg[k] = (k < 8) ? key_lo[8*k +: 8] : key_hi[8*(k-8) +: 8];
    msg[n] = obj[7:0];
    msg[n+1] = obj[15:8];
    msg[n+2] = obj[23:16];
    msg[n+5] = 8'h80;
    msg[56] = 8'((n + 5) * 8);
    msg[57] = 8'(((n + 5) * 8) >> 8);
    for (int k = 0; k < 16; k++) w[k] = {msg[4*k+3], msg[4*k+2], msg[4*k+1], msg[4*k]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int k = 0; k < 64; k++) begin
      if (k < 16) begin
        f = (b & c) | (~b & d); g = k;
      end else if (k < 32) begin
        f = (d & b) | (~d & c); g = (5*k + 1) % 16;
      end else if (k < 48) begin
        f = b ^ c ^ d; g = (3*k + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7*k) % 16;
      end
      t = d; d = c; c = b;
      s = a + f + SineTab[k] + w[g];
      b = b + ((s << ShiftTab[(k/16)*4 + k%4]) | (s >> (32 - ShiftTab[(k/16)*4 + k%4])));
      a = t;
    end
    dig[0] = 32'h67452301 + a; dig[1] = 32'hefcdab89 + b;
    dig[2] = 32'h98badcfe + c; dig[3] = 32'h10325476 + d;
    for (int k = 0; k < 16; k++) okey[k] = dig[k/4][8*(k%4) +: 8];
    klen = (n + 5 > DigestBytes) ? DigestBytes : n + 5;
    for (int i = 0; i < 256; i++) perm[i] = 8'(i);
    jj = 0;
    for (int i = 0; i < 256; i++) begin
      jj = jj + perm[i] + okey[i % klen];
      tmp = perm[i]; perm[i] = perm[jj]; perm[jj] = tmp;
    end
    ptr_i = 0;
    ptr_j = 0;
  endtask

  task automatic encipher(input logic [7:0] db, input logic lst);
    logic [7:0] tmp;
    cipher_out_t e;
    ptr_i = ptr_i + 1;
    ptr_j = ptr_j + perm[ptr_i];
    tmp = perm[ptr_i]; perm[ptr_i] = perm[ptr_j]; perm[ptr_j] = tmp;
    e.cipher_byte = db ^ perm[8'(perm[ptr_i] + perm[ptr_j])];
    e.last_flag = lst;
    cipher_q.push_back(e);
  endtask

  initial begin
    fail_count = 0;
    byte_count = 0;
    pending_count = 0;
    key_lo = 0; key_hi = 0; key_len = 5;
    ptr_i = 0; ptr_j = 0;
    for (int i = 0; i < 256; i++) perm[i] = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_KEY_LOW:  key_lo <= cfg_wdata;
          CFG_KEY_HIGH: key_hi <= cfg_wdata;
          CFG_KEY_LEN:  key_len <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser) schedule_object_key(in_tdata[23:0]);
        else encipher(in_tdata[31:24], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        byte_count++;
        if (cipher_q.size() == 0) begin
          report("unexpected byte", out_tdata, 0);
        end else begin
          cipher_out_t e;
          e = cipher_q.pop_front();
          if (out_tdata !== e.cipher_byte) report("out_byte", out_tdata, e.cipher_byte);
          if (out_tlast !== e.last_flag) report("out_last", out_tlast, e.last_flag);
        end
      end
    end
    pending_count = cipher_q.size();
  end
endmodule

// ===== tb/sv/tb_pdf_object_rc4_encrypt.sv =====
// ----------------------------------------------------------------------------
// tb_pdf_object_rc4_encrypt
// drives objects of random bytes through the per-object rc4 cipher under
// several file keys and key lengths; the checker predicts each byte
// ----------------------------------------------------------------------------
module tb_pdf_object_rc4_encrypt;
  import pdfrc4_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = 0;   // object_number[23:0], data_byte[31:24]
  logic        in_tuser = 0;   // mode
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [7:0]  out_tdata;      // out_byte
  logic        out_tlast;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [63:0] cfg_wdata = 0;

  int fail_count, pending_count, byte_count;
  int cycle_count = 0;
  int objects_sent = 0;
  int items_sent = 0;
  bit stall_free = 0;

  localparam int CycleLimit = 2000000;

  always #1 clk = ~clk;

  pdf_object_rc4_encrypt u_top (.*);

  pdf_rc4_checker u_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout");
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls in a pattern of its own, with stall-free stretches
  always @(negedge clk) begin
    if (stall_free || (cycle_count / 300) % 4 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one transfer on the input channel; valid stays high across back-to-back items
  task automatic send_item(input logic mode, input logic [23:0] obj,
                           input logic [7:0] db, input logic lst);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= mode ? {db, 24'(obj)} : {db, obj};
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (!mode) objects_sent++;
  endtask

  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
  endtask

  // an object: a start, then bytes, the final one marked last
  task automatic send_object(input logic [23:0] obj, input int len);
    send_item(1'b0, obj, 8'($urandom), 1'($urandom));
    maybe_gap();
    for (int k = 0; k < len; k++) begin
      send_item(1'b1, 24'($urandom), 8'($urandom), k == len - 1);
      maybe_gap();
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    // a start may still be running its key schedule
    repeat (1500) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset key, extremes of the object number and data bytes
    send_object(24'h000000, 0);
    send_item(1'b1, 24'h0, 8'h00, 1'b0);
    send_item(1'b1, 24'hffffff, 8'hff, 1'b1);
    send_object(24'hffffff, 3);
    // data after last keeps the keystream going
    send_item(1'b1, 24'h0, 8'h5a, 1'b0);
    send_item(1'b1, 24'h0, 8'ha5, 1'b1);
    drain();
    // register written mid-object takes effect only at the next start
    send_object(24'h123456, 2);
    drain();
    write_reg(CFG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    send_item(1'b1, 24'h0, 8'h81, 1'b1);
    drain();
    write_reg(CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_KEY_LEN, 64'd16);
    send_object(24'h800001, 4);
    drain();
    // out-of-range key lengths fall back to five
    write_reg(CFG_KEY_LEN, 64'd31);
    send_object(24'h00ff00, 2);
    drain();
    write_reg(CFG_KEY_LEN, 64'd0);
    send_object(24'h0000ff, 2);
    drain();

    // random phases, each with its own key setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_KEY_LOW, {$urandom, $urandom});
      write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
      case (ph)
        0: write_reg(CFG_KEY_LEN, 64'd5);
        1: write_reg(CFG_KEY_LEN, 64'd16);
        2: write_reg(CFG_KEY_LEN, 64'(32'($urandom_range(0, 31))));
        default: write_reg(CFG_KEY_LEN, 64'(32'($urandom_range(5, 16))));
      endcase
      stall_free = (ph == 3);
      for (int ob = 0; ob < 4; ob++)
        send_object(24'($urandom), $urandom_range(4, 30));
      // hold the sender until every byte is back
      drain();
    end

    drain();
    $display("covered %0d items in %0d objects, %0d bytes checked",
             items_sent, objects_sent, byte_count);
    $display("key lengths 5 to 16 plus out-of-range values, random stalls on both sides");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
